### hw/rtl/mvtb_pkg.sv
// Shared types and constants for the virtual timer bank.
// Used by mvtb_ctrl, mvtb_datapath and multiplexed_virtual_timer_bank.
package mvtb_pkg;

  // Command opcodes carried on the input tuser.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_RELEASE = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_UNCONF = 2'd2
  } stat_e;

  // Result kind carried on the output tuser.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned RELOAD_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_EMIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic exec_cmd;
    logic walk_step;
    logic emit_step;
    logic cnt_clear;
    logic cnt_inc;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_tick;
    logic is_cmd;
    logic out_free;
    logic cnt_last;
    logic mask_bit;
  } dp_stat_t;

endpackage

### hw/rtl/multiplexed_virtual_timer_bank.sv
// Top level of the virtual timer bank: stream ports, configuration port,
// controller and datapath. Depends on mvtb_pkg, mvtb_ctrl, mvtb_datapath.
//
// A bank of software-style timer slots advanced by an external tick beat
// (opcode 0). Set, start, stop and release beats address one slot and give
// exactly one status beat each (tlast high). A tick walks the slots in
// ascending order, one slot per cycle through the single port of the slot
// table, and then sweeps the expiry mask, one slot per cycle unless an
// expiry waits on the output, sending one expiry beat (tuser high) per
// slot that reached its reload; tlast marks the final expiry and a tick
// with no expiry sends nothing. One item is worked on at a time: a command
// goes from decode back to idle, a tick through decode, walk and emit;
// output stalls can hold either. The result register lets a new item be
// accepted while the last result still waits. max_reload is written through
// the cfg channel, which is always ready; write it only while the bank is idle.
module multiplexed_virtual_timer_bank
  import mvtb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot[2:0], reload_ticks[34:3], repeat_mode[35], zero
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // event_slot[2:0], status[4:3], zero
  output logic        m_axis_tuser,  // kind[0]
  output logic        m_axis_tlast,
  // max_reload write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic [SLOT_W-1:0] out_slot;
  logic [1:0]        out_status;

  // Always take configuration writes.
  assign cfg_ready_o = 1'b1;

  mvtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  mvtb_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_op_i      (s_axis_tuser),
    .in_slot_i    (s_axis_tdata[2:0]),
    .in_reload_i  (s_axis_tdata[34:3]),
    .in_repeat_i  (s_axis_tdata[35]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_slot_o   (out_slot),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result beat; pad to a whole byte.
  assign m_axis_tdata = {3'b000, out_status, out_slot};

  // A command result never overwrites a result still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.exec_cmd |-> dp_stat.out_free)
    else $error("command result loaded over a pending beat");

  // An expiry never overwrites a result still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.emit_step && dp_stat.mask_bit) |-> dp_stat.out_free)
    else $error("expiry loaded over a pending beat");

  // Every status beat closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_STATUS)) |-> m_axis_tlast)
    else $error("status beat without tlast");

  // Expiry beats always report success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_EXPIRY)) |-> (m_axis_tdata[4:3] == ST_OK))
    else $error("expiry beat with non-zero status");

endmodule

### hw/rtl/mvtb_ctrl.sv
// Sequencer for the virtual timer bank: accepts items, runs commands,
// walks slots on a tick and then emits expiries. Depends on mvtb_pkg.
module mvtb_ctrl
  import mvtb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.is_tick) begin
          state_d = S_WALK;
        end else if (!stat_i.is_cmd || stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat_i.cnt_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if ((!stat_i.mask_bit || stat_i.out_free) && stat_i.cnt_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_DECODE: begin
        if (stat_i.is_tick) begin
          cmd_o.cnt_clear = 1'b1;
        end else if (stat_i.is_cmd && stat_i.out_free) begin
          cmd_o.exec_cmd = 1'b1;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.cnt_clear = stat_i.cnt_last;
        cmd_o.cnt_inc   = !stat_i.cnt_last;
      end
      S_EMIT: begin
        if (!stat_i.mask_bit || stat_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          cmd_o.cnt_inc   = !stat_i.cnt_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### hw/rtl/mvtb_datapath.sv
// Slot table, item and walk registers, expiry mask and result register
// for the virtual timer bank. Depends on mvtb_pkg.
module mvtb_datapath
  import mvtb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS   = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [2:0]          in_op_i,
  input  logic [SLOT_W-1:0]   in_slot_i,
  input  logic [RELOAD_W-1:0] in_reload_i,
  input  logic                in_repeat_i,
  input  logic                cfg_valid_i,
  input  logic [RELOAD_W-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_kind_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [1:0]          out_status_o,
  output logic                out_last_o
);

  // Only the first eight slots are addressable by the slot field.
  localparam int unsigned DEPTH = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [RELOAD_W:0] COUNT_MAX = (RELOAD_W + 1)'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [2:0]          op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [RELOAD_W-1:0] reload_q;
  logic                repeat_q;
  logic [RELOAD_W-1:0] max_reload_q;
  logic [IDX_W-1:0]    cnt_q;
  logic [DEPTH-1:0]    mask_q, mask_d;

  logic [COUNT_WIDTH-1:0] elapsed_q [DEPTH];
  logic [COUNT_WIDTH-1:0] period_q  [DEPTH];
  logic [DEPTH-1:0]       periodic_q, running_q, registered_q;
  stat_e                  slot_stat_q [DEPTH];

  logic [IDX_W-1:0]       idx;
  logic                   slot_ok, reload_ok, wr_en;
  logic [COUNT_WIDTH-1:0] elapsed_rd, period_rd, elapsed_inc;
  logic [COUNT_WIDTH-1:0] elapsed_d, period_d;
  logic                   periodic_d, running_d, registered_d;
  stat_e                  slot_stat_rd, slot_stat_d;
  logic                   out_load;
  logic                   res_kind, res_last;
  logic [SLOT_W-1:0]      res_slot;
  logic [1:0]             res_status;
  logic [DEPTH-1:0]       mask_hi;

  logic                   out_valid_q;
  logic                   out_kind_q, out_last_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [1:0]             out_status_q;

  // Item and configuration registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= in_op_i;
      slot_q   <= in_slot_i;
      reload_q <= in_reload_i;
      repeat_q <= in_repeat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_reload_q <= '1;
    end else if (cfg_valid_i) begin
      max_reload_q <= cfg_data_i;
    end
  end

  // Walk counter and expiry mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mask_q <= '0;
    end else begin
      if (cmd_i.cnt_clear) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      mask_q <= mask_d;
    end
  end

  // One read/write port on the slot table.
  assign idx          = cmd_i.walk_step ? cnt_q : slot_q[IDX_W-1:0];
  assign elapsed_rd   = elapsed_q[idx];
  assign period_rd    = period_q[idx];
  assign slot_stat_rd = slot_stat_q[idx];
  assign elapsed_inc  = elapsed_rd + COUNT_WIDTH'(1);
  assign slot_ok      = (32'(slot_q) < NUM_SLOTS);
  assign reload_ok    = (reload_q <= max_reload_q) && ({1'b0, reload_q} <= COUNT_MAX);

  always_comb begin
    elapsed_d    = elapsed_rd;
    period_d     = period_rd;
    periodic_d   = periodic_q[idx];
    running_d    = running_q[idx];
    registered_d = registered_q[idx];
    slot_stat_d  = slot_stat_rd;
    wr_en        = 1'b0;
    mask_d       = cmd_i.load_item ? '0 : mask_q;
    res_status   = ST_OK;

    if (cmd_i.walk_step) begin
      wr_en = 1'b1;
      if (registered_q[idx] && running_q[idx]) begin
        if (elapsed_inc >= period_rd) begin
          elapsed_d   = '0;
          mask_d[idx] = 1'b1;
          if (!periodic_q[idx] && (slot_stat_rd == ST_OK)) running_d = 1'b0;
        end else begin
          elapsed_d = elapsed_inc;
        end
      end
    end else if (cmd_i.exec_cmd) begin
      if (!slot_ok) begin
        res_status = ST_UNCONF;
      end else begin
        wr_en = 1'b1;
        case (op_q)
          OP_SET: begin
            if (reload_ok) begin
              running_d    = 1'b0;
              elapsed_d    = '0;
              period_d     = reload_q[COUNT_WIDTH-1:0];
              periodic_d   = repeat_q;
              registered_d = 1'b1;
              slot_stat_d  = ST_OK;
            end else begin
              slot_stat_d = ST_RANGE;
            end
            res_status = slot_stat_d;
          end
          OP_START, OP_STOP: begin
            if (slot_stat_rd == ST_OK) begin
              running_d = (op_q == OP_START);
              elapsed_d = '0;
            end
            res_status = slot_stat_rd;
          end
          default: begin
            registered_d = 1'b0;
            running_d    = 1'b0;
            elapsed_d    = '0;
            slot_stat_d  = ST_UNCONF;
            res_status   = ST_OK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        elapsed_q[i]   <= '0;
        period_q[i]    <= '0;
        slot_stat_q[i] <= ST_UNCONF;
      end
      periodic_q   <= '0;
      running_q    <= '0;
      registered_q <= '0;
    end else if (wr_en) begin
      elapsed_q[idx]    <= elapsed_d;
      period_q[idx]     <= period_d;
      slot_stat_q[idx]  <= slot_stat_d;
      periodic_q[idx]   <= periodic_d;
      running_q[idx]    <= running_d;
      registered_q[idx] <= registered_d;
    end
  end

  // Result selection: a status for commands, an expiry during the emit pass.
  assign mask_hi = mask_q >> cnt_q;

  always_comb begin
    out_load = 1'b0;
    res_kind = KIND_STATUS;
    res_slot = slot_q;
    res_last = 1'b1;
    if (cmd_i.exec_cmd) begin
      out_load = 1'b1;
    end else if (cmd_i.emit_step && mask_q[cnt_q]) begin
      out_load = 1'b1;
      res_kind = KIND_EXPIRY;
      res_slot = SLOT_W'(cnt_q);
      res_last = ((mask_hi >> 1) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= res_kind;
      out_slot_q   <= res_slot;
      out_status_q <= res_status;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_slot_o   = out_slot_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  assign stat_o.is_tick  = (op_q == OP_TICK);
  assign stat_o.is_cmd   = (op_q == OP_SET) || (op_q == OP_START) ||
                           (op_q == OP_STOP) || (op_q == OP_RELEASE);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.cnt_last = (cnt_q == IDX_W'(DEPTH - 1));
  assign stat_o.mask_bit = mask_q[cnt_q];

endmodule

### sim/multiplexed_virtual_timer_bank_test.sv
// Self-checking testbench for multiplexed_virtual_timer_bank: sends command and tick beats,
// predicts the status and expiry beats of the timer slots, and checks them in order.
// Depends on mvtb_pkg and the bank RTL.
module multiplexed_virtual_timer_bank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mvtb_pkg::*;

  localparam int N_SLOTS       = 8;
  localparam int SEND_GAP_MAX  = 11;
  localparam int SINK_GAP_MAX  = 11;
  // Long receiver hold-off; far longer than the bank needs to back up.
  localparam int LONG_HOLD     = 400;
  // A tick with no output only walks and sweeps the slots; give it ample room.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 400000;

  // One expected beat on the result stream.
  typedef struct {
    logic        kind;
    logic [2:0]  slot;
    stat_e       status;
    logic        last;
  } timer_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // slot[2:0], reload_ticks[34:3], repeat_mode[35], zero
  logic [2:0]  s_axis_tuser  = '0;  // opcode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // event_slot[2:0], status[4:3], zero
  logic        m_axis_tuser;        // kind[0]
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;

  // Shared between the stimulus and the receiver process.
  bit sender_burst  = 1'b0;
  bit sink_burst    = 1'b0;
  bit long_hold_req = 1'b0;
  int cycle_count   = 0;

  // Slot table mirror: computes the beats each accepted item causes and
  // holds them until the bank sends them.
  class timer_scoreboard;
    logic [31:0]   max_reload;
    logic [31:0]   elapsed     [N_SLOTS];
    logic [31:0]   period      [N_SLOTS];
    bit            periodic    [N_SLOTS];
    bit            running     [N_SLOTS];
    bit            registered  [N_SLOTS];
    stat_e         slot_status [N_SLOTS];
    timer_result_t due_q[$];
    int            fail_count;

    function new();
      max_reload = 32'hFFFF_FFFF;
      fail_count = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
        elapsed[i]     = '0;
        period[i]      = '0;
        periodic[i]    = 1'b0;
        running[i]     = 1'b0;
        registered[i]  = 1'b0;
        slot_status[i] = ST_UNCONF;
      end
    endfunction

    function void note_input(logic [2:0] op, logic [2:0] slot, logic [31:0] reload,
                             logic rep);
      timer_result_t r;
      int            first;
      first    = due_q.size();
      r.kind   = KIND_STATUS;
      r.slot   = slot;
      r.status = ST_OK;
      r.last   = 1'b1;
      case (op)
        OP_TICK: begin
          // Walk registered, running slots in ascending order.
          for (int i = 0; i < N_SLOTS; i++) begin
            if (registered[i] && running[i]) begin
              elapsed[i] = elapsed[i] + 32'd1;
              if (elapsed[i] >= period[i]) begin
                elapsed[i] = '0;
                r.kind     = KIND_EXPIRY;
                r.slot     = 3'(i);
                r.status   = ST_OK;
                r.last     = 1'b0;
                due_q.push_back(r);
                // One-shot stops only when its set succeeded.
                if (!periodic[i] && slot_status[i] == ST_OK) running[i] = 1'b0;
              end
            end
          end
          if (due_q.size() > first) begin
            r      = due_q.pop_back();
            r.last = 1'b1;
            due_q.push_back(r);
          end
        end
        OP_SET: begin
          if (reload > max_reload) begin
            slot_status[slot] = ST_RANGE;
          end else begin
            running[slot]     = 1'b0;
            elapsed[slot]     = '0;
            period[slot]      = reload;
            periodic[slot]    = rep;
            registered[slot]  = 1'b1;
            slot_status[slot] = ST_OK;
          end
          r.status = slot_status[slot];
          due_q.push_back(r);
        end
        OP_START, OP_STOP: begin
          if (slot_status[slot] == ST_OK) begin
            running[slot] = (op == OP_START);
            elapsed[slot] = '0;
          end
          r.status = slot_status[slot];
          due_q.push_back(r);
        end
        OP_RELEASE: begin
          registered[slot]  = 1'b0;
          running[slot]     = 1'b0;
          elapsed[slot]     = '0;
          slot_status[slot] = ST_UNCONF;
          due_q.push_back(r);
        end
        default: ;  // unused opcodes give nothing
      endcase
    endfunction

    function void check_result(logic kind, logic [2:0] slot, logic [1:0] status, logic last);
      timer_result_t want;
      if (due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected beat kind %0d slot %0d status %0d last %0d",
                   $time, kind, slot, status, last);
        return;
      end
      want = due_q.pop_front();
      if (want.kind !== kind || want.slot !== slot || want.status !== status ||
          want.last !== last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch, expected kind %0d slot %0d status %0d last %0d",
                   $time, want.kind, want.slot, want.status, want.last);
          $display("  got kind %0d slot %0d status %0d last %0d", kind, slot, status, last);
        end
      end
    endfunction
  endclass

  timer_scoreboard sb = new();

  multiplexed_virtual_timer_bank u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multiplexed_virtual_timer_bank test failed");
      $finish;
    end
  end

  // Sample both streams at the edge; register outputs settle only after it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[35]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tlast);
  end

  // Receiver: stall a random number of cycles before each beat, run stretches
  // without stalls, and serve one long hold-off when asked.
  initial begin : sink
    int gap;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
      if (long_hold_req) begin
        gap           = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        gap = sink_burst ? 0 : $urandom_range(0, SINK_GAP_MAX);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one beat after a random gap; return at the edge that accepts it.
  // Keep tvalid high across back-to-back beats.
  task automatic send_beat(input logic [2:0] op, input logic [2:0] slot,
                           input logic [31:0] reload, input logic rep);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, SEND_GAP_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, rep, reload, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the input until every expected beat is out, then let a tick finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_reload; call only with the bank idle.
  task automatic write_max_reload(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    sb.max_reload = value;
  endtask

  // Mostly short periods so slots expire often; sometimes the range edge or any value.
  function automatic logic [31:0] pick_reload();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 32'($urandom_range(0, 6));
    if (r == 7) return sb.max_reload;
    if (r == 8) return (sb.max_reload == 32'hFFFF_FFFF) ? sb.max_reload : sb.max_reload + 1;
    return $urandom;
  endfunction

  // Random traffic: a quarter are set/start/tick sequences on one slot, the
  // rest single commands, ticks and unused opcodes with random filler in the unused fields.
  task automatic random_phase(input int goal);
    int          sent;
    int          pick;
    int          n;
    logic [2:0]  slot;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
      slot = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = $urandom_range(1, 4);
        send_beat(OP_SET, slot, pick_reload(), 1'($urandom_range(0, 1)));
        send_beat(OP_START, slot, $urandom, 1'($urandom_range(0, 1)));
        repeat (n) send_beat(OP_TICK, 3'($urandom_range(0, 7)), $urandom,
                             1'($urandom_range(0, 1)));
        sent += 2 + n;
      end else if (pick < 94) begin
        if (pick < 55)
          send_beat(OP_TICK, slot, $urandom, 1'($urandom_range(0, 1)));
        else if (pick < 70)
          send_beat(OP_SET, slot, pick_reload(), 1'($urandom_range(0, 1)));
        else if (pick < 80)
          send_beat(OP_START, slot, $urandom, 1'($urandom_range(0, 1)));
        else if (pick < 87)
          send_beat(OP_STOP, slot, $urandom, 1'($urandom_range(0, 1)));
        else
          send_beat(OP_RELEASE, slot, $urandom, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // Unused opcode: ignored by the bank, not counted.
        send_beat(3'($urandom_range(5, 7)), slot, $urandom, 1'($urandom_range(0, 1)));
      end
    end
    sender_burst = 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] limits [5];
    int          waited;
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'd4;
    limits[2] = 32'h8000_0000;
    limits[3] = $urandom | 32'd1;
    limits[4] = 32'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: commands on unset slots, zero and full-range reloads,
    // one-shot expiry, release twice, unused opcodes.
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);  // nothing registered
    send_beat(OP_START,   3'd0, 32'h0,         1'b0);  // not configured
    send_beat(OP_STOP,    3'd7, 32'hFFFF_FFFF, 1'b1);  // not configured
    send_beat(OP_SET,     3'd0, 32'h0,         1'b1);  // zero reload, periodic
    send_beat(OP_START,   3'd0, 32'h0,         1'b0);
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);  // expires every tick
    send_beat(OP_TICK,    3'd5, 32'h0,         1'b0);
    send_beat(OP_SET,     3'd7, 32'hFFFF_FFFF, 1'b0);  // reload at max_reload
    send_beat(OP_START,   3'd7, 32'h0,         1'b0);
    send_beat(OP_SET,     3'd3, 32'd2,         1'b0);  // one-shot, period 2
    send_beat(OP_START,   3'd3, 32'h0,         1'b0);
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);  // two expiries, slot 3 stops
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);
    send_beat(3'd5,       3'd1, 32'h1234_5678, 1'b1);  // ignored
    send_beat(3'd7,       3'd2, 32'hFFFF_FFFF, 1'b1);  // ignored
    send_beat(OP_RELEASE, 3'd0, 32'h0,         1'b0);
    send_beat(OP_RELEASE, 3'd0, 32'h0,         1'b0);  // already released
    send_beat(OP_STOP,    3'd7, 32'h0,         1'b0);
    send_beat(3'd6,       3'd4, 32'h0,         1'b0);  // ignored
    drain();

    // Smallest max_reload: a failed set leaves a one-shot slot running, so
    // its expiry restarts the count without stopping it.
    write_max_reload(32'd1);
    send_beat(OP_SET,     3'd5, 32'd1,         1'b0);
    send_beat(OP_START,   3'd5, 32'h0,         1'b0);
    send_beat(OP_SET,     3'd5, 32'd2,         1'b0);  // out of range
    send_beat(OP_START,   3'd5, 32'h0,         1'b0);  // reports range status
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);
    send_beat(OP_TICK,    3'd0, 32'h0,         1'b0);  // still running
    send_beat(OP_STOP,    3'd5, 32'h0,         1'b0);
    send_beat(OP_RELEASE, 3'd5, 32'h0,         1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_max_reload(limits[p]);
      if (p == 1) begin
        // Stall the receiver while the sender pushes back to back, so the
        // bank fills and holds its input.
        long_hold_req = 1'b1;
        sender_burst  = 1'b1;
        for (int s = 0; s < 4; s++) begin
          send_beat(OP_SET, 3'(s), 32'h0, 1'b1);
          send_beat(OP_START, 3'(s), 32'h0, 1'b0);
        end
        repeat (6) send_beat(OP_TICK, 3'd0, 32'h0, 1'b0);
        sender_burst = 1'b0;
      end
      random_phase(12);
      if (p == 2) drain();  // pause mid-phase until all beats are out
      random_phase(12);
      drain();
    end

    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.due_q.size() > 0) begin
      sb.fail_count++;
      $display("%0d expected beats never arrived", sb.due_q.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.fail_count == 0) begin
      $display("multiplexed_virtual_timer_bank test passed");
    end else begin
      $display("multiplexed_virtual_timer_bank test failed");
    end
    $finish;
  end

endmodule
